### design/sdl_pkg.sv
// Shared types and constants for the string dictionary lookup/insert unit.
// No dependencies; imported by sdl_entry_ram and the top level.
package sdl_pkg;

  localparam int unsigned DefDepth    = 64;
  localparam int unsigned DefKeyBytes = 8;

  localparam int unsigned KeyPortW = 64;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned OccW     = 7;
  localparam int unsigned OutDataW = 16;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned MaxEntW   = 7;
  localparam int unsigned KeyLenW   = 4;

  localparam logic [CfgIdxW-1:0] CfgMaxEntries = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgKeyLength  = CfgIdxW'(1);

  localparam logic [MaxEntW-1:0] MaxEntriesRst = MaxEntW'(64);
  localparam logic [KeyLenW-1:0] KeyLengthRst  = KeyLenW'(8);

  typedef enum logic [StatusW-1:0] {
    StatFound    = 2'd0,
    StatInserted = 2'd1,
    StatFull     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StResult
  } state_e;

endpackage

### design/sdl_entry_ram.sv
// Entry store of the dictionary: one write port, one read port, registered read data.
// Depends on sdl_pkg.
module sdl_entry_ram
  import sdl_pkg::*;
#(
  parameter int unsigned Depth = DefDepth,
  parameter int unsigned Width = 8 * DefKeyBytes,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/string_dictionary_lookup_insert_unit.sv
// Top level of the string dictionary lookup/insert unit: control, scan and result register.
// Depends on sdl_pkg and sdl_entry_ram.
//
//   Channel  Direction  Handshake                 Contents
//   s_axis   in         s_axis_tvalid/tready      key
//   m_axis   out        m_axis_tvalid/tready      status, index, occupancy
//   cfg      in         cfg_valid_i/cfg_ready_o   register index and value
//
// A miss scans every stored entry before a result is loaded; a match ends the scan sooner.
// The next key is accepted no earlier than the cycle after the result is loaded, so keys are not overlapped.
// The scan reads one stored entry per cycle through the single read port of the entry store.
// Reset clears the occupancy and loads the register defaults; the entry store needs no clearing pass.
// A result waits in the output register while the next key is accepted and scanned.
module string_dictionary_lookup_insert_unit
  import sdl_pkg::*;
#(
  parameter int unsigned DEPTH     = DefDepth,
  parameter int unsigned KEY_BYTES = DefKeyBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [KeyPortW-1:0] s_axis_tdata,   // key[63:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // status[1:0], index[7:2], occupancy[14:8], zero
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned KeyW  = 8 * KEY_BYTES;
  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > MaxEntW) ? CntW : MaxEntW;

  state_e state_q, state_d;

  logic [MaxEntW-1:0] max_entries_q;
  logic [KeyLenW-1:0] key_length_q;
  logic [KeyLenW-1:0] len_eff;
  logic [CmpW-1:0]    cap_eff;

  logic [CntW-1:0]  count_q, count_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [CntW-1:0]  rd_addr_q, rd_addr_d;
  logic             pend_q, pend_d;
  logic [AddrW-1:0] cmp_idx_q, cmp_idx_d;

  status_e          res_status_q, res_status_d;
  logic [AddrW-1:0] res_index_q, res_index_d;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic            in_fire;
  logic            out_load;
  logic [KeyW-1:0] key_masked;
  logic [KeyW-1:0] rd_data;
  logic            match;
  logic            hit;
  logic            issue;
  logic            room;
  logic            ram_we;
  logic            ram_re;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MaxEntriesRst;
      key_length_q  <= KeyLengthRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMaxEntries: max_entries_q <= cfg_data_i[MaxEntW-1:0];
        CfgKeyLength:  key_length_q  <= cfg_data_i[KeyLenW-1:0];
        default:       ;
      endcase
    end
  end

  assign len_eff = (key_length_q > KeyLenW'(KEY_BYTES)) ? KeyLenW'(KEY_BYTES) : key_length_q;
  assign cap_eff = (CmpW'(max_entries_q) > CmpW'(DEPTH)) ? CmpW'(DEPTH) : CmpW'(max_entries_q);
  assign room    = CmpW'(count_q) < cap_eff;

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == StResult) && (!out_valid_q || m_axis_tready);

  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_masked[8*b +: 8] = (KeyLenW'(b) < len_eff) ? s_axis_tdata[8*b +: 8] : 8'd0;
    end
  end

  always_comb begin
    logic done;
    match = 1'b1;
    done  = 1'b0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (!done && (KeyLenW'(b) < len_eff)) begin
        if (key_q[8*b +: 8] != rd_data[8*b +: 8]) begin
          match = 1'b0;
          done  = 1'b1;
        end else if (key_q[8*b +: 8] == 8'd0) begin
          done = 1'b1;
        end
      end
    end
  end

  assign hit    = (state_q == StScan) && pend_q && match;
  assign issue  = (state_q == StScan) && !hit && (rd_addr_q < count_q);
  assign ram_re = issue;
  assign ram_we = (state_q == StScan) && !hit && !issue && room;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (!issue) begin
          state_d = StResult;
        end
      end
      StResult: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    key_d        = key_q;
    count_d      = count_q;
    rd_addr_d    = rd_addr_q;
    pend_d       = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          key_d     = key_masked;
          rd_addr_d = '0;
        end
      end
      StScan: begin
        if (hit) begin
          res_status_d = StatFound;
          res_index_d  = cmp_idx_q;
        end else if (issue) begin
          pend_d    = 1'b1;
          cmp_idx_d = rd_addr_q[AddrW-1:0];
          rd_addr_d = rd_addr_q + CntW'(1);
        end else if (room) begin
          res_status_d = StatInserted;
          res_index_d  = count_q[AddrW-1:0];
          count_d      = count_q + CntW'(1);
        end else begin
          res_status_d = StatFull;
          res_index_d  = '0;
        end
      end
      StResult: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, OccW'(count_q), IndexW'(res_index_q), res_status_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    rd_addr_q    <= rd_addr_d;
    cmp_idx_q    <= cmp_idx_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    out_data_q   <= out_data_d;
  end

  sdl_entry_ram #(
    .Depth (DEPTH),
    .Width (KeyW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (rd_addr_q[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("occupancy above depth");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("entry store read and write in one cycle");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StScan) && !pend_q)
    else $error("accepted key did not start a scan");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("illegal status code");

endmodule

### verif/sdl_lookup_checker.sv
// Lookup checker for the string dictionary unit: watches the key, result and register channels.
// Predicts found, inserted or full for every accepted key and compares each result field.
// Depends on sdl_pkg for widths, register indexes and the status codes.
`timescale 1ns / 1ps

module sdl_lookup_checker
  import sdl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [KeyPortW-1:0] s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         pending_o,
  output int unsigned         mismatches_o
);

  typedef struct {
    status_e             status;
    logic [IndexW-1:0]   index;
    logic [OccW-1:0]     occ;
  } lookup_reply_t;

  lookup_reply_t       expected_replies[$];
  logic [KeyPortW-1:0] dict_keys[DefDepth];
  int unsigned         dict_count;
  logic [MaxEntW-1:0]  capacity_q;
  logic [KeyLenW-1:0]  key_len_q;
  int unsigned         mismatches;

  initial begin
    pending_o    = 0;
    mismatches_o = 0;
    mismatches   = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  // Comparison stops early with a match at the first NUL byte the two keys share.
  function automatic logic keys_equal(input logic [KeyPortW-1:0] a, input logic [KeyPortW-1:0] b,
                                      input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if (a[8*i +: 8] != b[8*i +: 8]) return 1'b0;
      if (a[8*i +: 8] == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic lookup_reply_t lookup_or_insert(input logic [KeyPortW-1:0] key);
    lookup_reply_t       r;
    int unsigned         len;
    int unsigned         cap;
    int unsigned         i;
    logic                hit;
    logic [KeyPortW-1:0] kept;
    len = (key_len_q > DefKeyBytes) ? DefKeyBytes : key_len_q;
    cap = (capacity_q > DefDepth) ? DefDepth : capacity_q;
    r.status = StatFull;
    r.index  = '0;
    hit      = 1'b0;
    for (i = 0; i < dict_count && !hit; i++) begin
      if (keys_equal(key, dict_keys[i], len)) begin
        hit      = 1'b1;
        r.status = StatFound;
        r.index  = IndexW'(i);
      end
    end
    if (!hit && dict_count < cap) begin
      kept = key;
      for (i = len; i < DefKeyBytes; i++) kept[8*i +: 8] = 8'h00;
      dict_keys[dict_count] = kept;
      r.index  = IndexW'(dict_count);
      r.status = StatInserted;
      dict_count++;
    end
    r.occ = OccW'(dict_count);
    return r;
  endfunction

  task automatic check_reply(input logic [OutDataW-1:0] got);
    lookup_reply_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch($sformatf("result 0x%04h arrived with no request outstanding", got));
    end else begin
      want = expected_replies.pop_front();
      if (got[1:0] != want.status) begin
        report_mismatch($sformatf("status %0d, expected %0d", got[1:0], want.status));
      end
      if (got[7:2] != want.index) begin
        report_mismatch($sformatf("index %0d, expected %0d", got[7:2], want.index));
      end
      if (got[14:8] != want.occ) begin
        report_mismatch($sformatf("occupancy %0d, expected %0d", got[14:8], want.occ));
      end
      if (got[OutDataW-1] !== 1'b0) begin
        report_mismatch($sformatf("padding bit set in result 0x%04h", got));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_replies.delete();
      dict_count   = 0;
      capacity_q   = MaxEntriesRst;
      key_len_q    = KeyLengthRst;
      pending_o    <= 0;
      mismatches_o <= mismatches;
    end else begin
      if (m_tvalid_i && m_tready_i) check_reply(m_tdata_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgMaxEntries: capacity_q = cfg_data_i[MaxEntW-1:0];
          CfgKeyLength:  key_len_q  = cfg_data_i[KeyLenW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) expected_replies.push_back(lookup_or_insert(s_tdata_i));
      pending_o    <= expected_replies.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

### verif/tb_top.sv
// Testbench top for string_dictionary_lookup_insert_unit: clock, reset, key and register stimulus.
// Instantiates the unit beside sdl_lookup_checker, which predicts and compares every result.
// Depends on sdl_pkg, the unit and the checker module.
`timescale 1ns / 1ps

module tb_top;
  import sdl_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpareA = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpareB = CfgIdxW'(3);
  localparam int unsigned        NumPhases = 12;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [KeyPortW-1:0] s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int unsigned         replies_pending;
  int unsigned         mismatch_total;

  logic [KeyPortW-1:0] key_pool[$];
  int unsigned         key_len_now   = DefKeyBytes;
  int unsigned         keys_sent     = 0;
  int unsigned         reg_writes    = 0;
  int unsigned         burst_left    = 0;
  logic                valid_held    = 1'b0;

  int unsigned         stall_mode;
  int unsigned         stall_left;
  logic [7:0]          ready_pattern;

  int unsigned         phase_cap[NumPhases] = '{12, 0, 20, 28, 36, 44, 52, 58, 64, 127, 100, 64};
  int unsigned         phase_len[NumPhases] = '{8, 4, 1, 2, 8, 5, 3, 7, 6, 15, 0, 8};

  always #5 clk_i = ~clk_i;

  string_dictionary_lookup_insert_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  sdl_lookup_checker lookup_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (replies_pending),
    .mismatches_o (mismatch_total)
  );

  // The result side switches between free flow, random stalls, rare acceptance and a rotating mask.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode    = 0;
      stall_left    = 0;
      ready_pattern = 8'hA5;
    end else begin
      if (stall_left == 0) begin
        stall_mode    = $urandom_range(0, 3);
        stall_left    = $urandom_range(50, 400);
        ready_pattern = 8'($urandom) | 8'h01;
      end else begin
        stall_left--;
      end
      ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ready_pattern[0];
      endcase
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    if (idx == CfgKeyLength) key_len_now = data[KeyLenW-1:0];
    @(posedge clk_i);
  endtask

  task automatic release_valid();
    if (valid_held) begin
      s_axis_tvalid <= 1'b0;
      valid_held    = 1'b0;
    end
  endtask

  task automatic push_key(input logic [KeyPortW-1:0] k);
    s_axis_tdata  <= k;
    s_axis_tvalid <= 1'b1;
    valid_held    = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    keys_sent++;
    key_pool.push_back(k);
    if (key_pool.size() > 48) key_pool.delete(0);
  endtask

  task automatic send_key(input logic [KeyPortW-1:0] k);
    int unsigned gap;
    push_key(k);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      release_valid();
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 10);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic drain_replies();
    release_valid();
    @(posedge clk_i);
    while (replies_pending != 0) @(posedge clk_i);
  endtask

  // Half of the keys repeat or vary a recent key in its ignored bytes so that lookups hit.
  function automatic logic [KeyPortW-1:0] make_key();
    logic [KeyPortW-1:0] k;
    int unsigned         sel;
    int unsigned         len;
    int unsigned         tail;
    int unsigned         n;
    int unsigned         b;
    len = (key_len_now > DefKeyBytes) ? DefKeyBytes : key_len_now;
    sel = (key_pool.size() == 0) ? 60 : $urandom_range(0, 99);
    k   = (key_pool.size() == 0) ? '0 : key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (sel < 30) begin
      return k;
    end else if (sel < 50) begin
      tail = len;
      for (b = 0; b < len; b++) begin
        if (k[8*b +: 8] == 8'h00) begin
          tail = b + 1;
          break;
        end
      end
      for (b = tail; b < DefKeyBytes; b++) k[8*b +: 8] = 8'($urandom);
    end else if (sel < 70) begin
      n = $urandom_range(0, DefKeyBytes);
      k = '0;
      for (b = 0; b < n; b++) k[8*b +: 8] = 8'h61 + 8'($urandom_range(0, 3));
    end else if (sel < 85) begin
      k[$urandom_range(0, KeyPortW - 1)] ^= 1'b1;
    end else begin
      k = {$urandom, $urandom};
    end
    return k;
  endfunction

  initial begin
    int unsigned p;
    int unsigned i;
    int unsigned count;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Capacity zero on an empty table: everything is refused; spare indexes are ignored.
    write_reg(CfgMaxEntries, 7'd0);
    write_reg(CfgKeyLength, 7'd8);
    write_reg(CfgSpareA, 7'h7F);
    write_reg(CfgSpareB, 7'h55);
    send_key(64'h0);
    send_key(64'hFFFF_FFFF_FFFF_FFFF);
    drain_replies();

    // Key length zero: an empty table stores a zero key, then every key finds entry 0.
    write_reg(CfgKeyLength, 7'd0);
    write_reg(CfgMaxEntries, 7'd1);
    send_key(64'hFFFF_FFFF_FFFF_FFFF);
    send_key(64'h1357_9BDF_2468_ACE0);
    drain_replies();

    // Full length: keys equal up to a shared NUL match; the table then fills up.
    write_reg(CfgKeyLength, 7'd8);
    write_reg(CfgMaxEntries, 7'd4);
    send_key(64'h0000_0000_5800_6261);
    send_key(64'h0000_0000_5900_6261);
    send_key(64'h0);
    send_key(64'hFFFF_FFFF_FFFF_FFFF);
    send_key(64'h8000_0000_0000_0001);
    send_key(64'h0123_4567_89AB_CDEF);
    drain_replies();

    // Register values above the limits saturate to the table depth and to eight bytes.
    write_reg(CfgMaxEntries, 7'h7F);
    write_reg(CfgKeyLength, 7'h7F);
    send_key(64'hFFFF_FFFF_FFFF_FFFF);
    send_key(64'h7FFF_FFFF_FFFF_FFFF);
    send_key(64'h0123_4567_89AB_CDEF);
    drain_replies();

    // Short keys keep only their leading bytes; older entries keep what they stored.
    write_reg(CfgKeyLength, 7'd3);
    send_key(64'h00AA_BBCC_DDEE_FF11);
    send_key(64'h1234_5678_99EE_FF11);
    send_key(64'h0000_0000_0000_FF11);
    drain_replies();
    write_reg(CfgKeyLength, 7'd1);
    send_key(64'h0000_0000_0000_0061);
    drain_replies();

    for (p = 0; p < NumPhases; p++) begin
      write_reg(CfgMaxEntries, CfgDataW'(phase_cap[p]));
      write_reg(CfgKeyLength, CfgDataW'(phase_len[p]) | (CfgDataW'($urandom_range(0, 7)) << 4));
      count = (phase_len[p] == 0) ? 30 : 115;
      for (i = 0; i < count; i++) begin
        send_key(make_key());
        if ($urandom_range(0, 199) == 0) drain_replies();
      end
      drain_replies();
    end

    repeat (DefDepth + 8) @(posedge clk_i);
    $display("Summary: %0d keys sent over %0d register writes, capacity 0 to 127,",
             keys_sent, reg_writes);
    $display("Summary: key length 0 to 15, table grown to its full depth under random stalls.");
    if (mismatch_total == 0 && replies_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("Timed out with %0d results outstanding", replies_pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule
